### rtl/nenv_pkg.sv
// Package for the note envelope with glide block: beat structs, field widths,
// configuration register codes and reset values.
// No dependencies; every module of the block imports it.
package nenv_pkg;

    // Field widths fixed by the interface
    localparam int FREQ_W       = 24;  // frequency words on the ports
    localparam int VEL_W        = 16;  // velocity, Q0.16
    localparam int LEVEL_W      = 24;  // envelope level and target, Q0.24
    localparam int LEVEL_OUT_W  = 16;  // output level, Q0.16
    localparam int FRAMES_W     = 23;  // attack / release frame counts
    localparam int FADE_W       = 16;  // Q0.16 coefficients
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 23;

    // Left shift that puts the Q0.24 envelope under a Q0.16 root
    localparam int ENV_SHIFT    = 2 * LEVEL_OUT_W - LEVEL_W;

    // Rounding constant for Q0.16 products (one half LSB)
    localparam int ROUND_HALF   = 1 << (FADE_W - 1);

    // Default module parameters
    localparam int FREQ_BITS_DEF  = 24;
    localparam int COUNT_BITS_DEF = 24;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ATTACK_FRAMES  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_FRAMES = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ATTACK_FADE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_FADE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FREQ_FADE      = 3'd4;

    // Configuration reset values
    localparam logic [FRAMES_W-1:0] RST_ATTACK_FRAMES  = 23'd2205;
    localparam logic [FRAMES_W-1:0] RST_RELEASE_FRAMES = 23'd2205;
    localparam logic [FADE_W-1:0]   RST_ATTACK_FADE    = 16'd205;
    localparam logic [FADE_W-1:0]   RST_RELEASE_FADE   = 16'd205;
    localparam logic [FADE_W-1:0]   RST_FREQ_FADE      = 16'd6554;

    // Input beat: one audio frame
    typedef struct packed {
        logic [FREQ_W-1:0] freq_target;
        logic [VEL_W-1:0]  velocity;
    } t_in_beat;

    // Output beat: one result per frame
    typedef struct packed {
        logic [FREQ_W-1:0]      frequency;
        logic [LEVEL_OUT_W-1:0] level;
    } t_out_beat;

endpackage

### rtl/nenv_sqrt.sv
// Iterative floor square root, one result bit per cycle.
// Depends on nenv_pkg for the default root width.
module nenv_sqrt #(
    parameter int ROOT_W = nenv_pkg::LEVEL_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [2*ROOT_W-1:0]   i_radicand,
    output logic                  o_done,
    output logic [ROOT_W-1:0]     o_root
);
    import nenv_pkg::*;

    localparam int CNT_W = (ROOT_W > 2) ? $clog2(ROOT_W) : 1;
    localparam int REM_W = ROOT_W + 2;

    logic [2*ROOT_W-1:0] r_rad;
    logic [REM_W-1:0]    r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [REM_W+1:0]    rem_sh;
    logic [REM_W+1:0]    trial;
    logic [REM_W+1:0]    rem_sub;
    logic                fits;

    // Bring down the next two radicand bits and try the next root bit
    always_comb begin
        rem_sh  = {r_rem, r_rad[2*ROOT_W-1 -: 2]};
        trial   = {2'b00, r_root, 2'b01};
        fits    = (rem_sh >= trial);
        rem_sub = rem_sh - trial;
    end

    // Sequence the iterations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ROOT_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Advance remainder and root
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[2*ROOT_W-3:0], 2'b00};
            r_rem  <= fits ? REM_W'(rem_sub) : REM_W'(rem_sh);
            r_root <= {r_root[ROOT_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### rtl/nenv_mul.sv
// Shared Q0.16 scaling unit: registered product of a coefficient and a
// magnitude, rounded half up on the way out. Depends on nenv_pkg.
module nenv_mul #(
    parameter int B_W = nenv_pkg::LEVEL_W
) (
    input  logic                        i_clk,
    input  logic [nenv_pkg::FADE_W-1:0] i_coef,
    input  logic [B_W-1:0]              i_mag,
    output logic [B_W-1:0]              o_step
);
    import nenv_pkg::*;

    localparam int P_W = FADE_W + B_W;

    logic [P_W-1:0] r_prod;
    logic [P_W:0]   rounded;

    // Register the product
    always_ff @(posedge i_clk) begin
        r_prod <= P_W'(i_coef) * P_W'(i_mag);
    end

    // Round half up and drop the fraction
    always_comb begin
        rounded = (P_W + 1)'(r_prod) + (P_W + 1)'(ROUND_HALF);
        o_step  = rounded[P_W-1:FADE_W];
    end

endmodule

### rtl/note_envelope_with_glide_top.sv
// Note envelope with glide. One input beat per audio frame carries a target
// frequency word (zero is note off) and a Q0.16 velocity; each frame gives one
// output beat with the gliding frequency and the Q0.16 square root of the
// Q0.24 envelope. Most of a frame goes to two 24-step passes through the
// shared bit-serial square root unit (velocity root, then level root), the
// rest to the frame counter and the shared multiplier for the envelope
// smoothing and the glide. The input is ready only while the block is idle
// and is ready again in the cycle the result turns valid, so a new frame is
// taken only once the last one is through; a finished result sits in an
// output register, so the next frame is taken while it waits, and only a
// second finished result stalls until the first beat is taken. Configuration
// writes are taken only while the block is idle; a write at the edge that
// takes an input beat applies to that frame.
module note_envelope_with_glide_top #(
    parameter int FREQ_BITS  = nenv_pkg::FREQ_BITS_DEF,
    parameter int COUNT_BITS = nenv_pkg::COUNT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Frame input
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  nenv_pkg::t_in_beat               i_in_data,
    // Result output
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output nenv_pkg::t_out_beat              o_out_data,
    // Configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [nenv_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [nenv_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import nenv_pkg::*;

    // Datapath width of the shared multiplier
    localparam int DW = (FREQ_BITS > LEVEL_W) ? FREQ_BITS : LEVEL_W;
    // Counter work width: holds every compare operand in full
    localparam int CW = ((COUNT_BITS > LEVEL_W) ? COUNT_BITS : LEVEL_W) + 1;

    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_VROOT     = 14'b00000000000010,
        S_CNT_PRE   = 14'b00000000000100,
        S_CNT_UPD   = 14'b00000000001000,
        S_ENV_DIF   = 14'b00000000010000,
        S_ENV_MUL   = 14'b00000000100000,
        S_ENV_UPD   = 14'b00000001000000,
        S_GLD_SQ    = 14'b00000010000000,
        S_GLD_DIF   = 14'b00000100000000,
        S_GLD_MUL   = 14'b00001000000000,
        S_GLD_UPD   = 14'b00010000000000,
        S_LVL_START = 14'b00100000000000,
        S_LVL_ROOT  = 14'b01000000000000,
        S_EMIT      = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers
    logic [FRAMES_W-1:0] r_attack_frames;
    logic [FRAMES_W-1:0] r_release_frames;
    logic [FADE_W-1:0]   r_attack_fade;
    logic [FADE_W-1:0]   r_release_fade;
    logic [FADE_W-1:0]   r_freq_fade;

    // Block state
    logic [COUNT_BITS-1:0] r_phase;
    logic [LEVEL_W-1:0]    r_env_level;
    logic [LEVEL_W-1:0]    r_env_tgt;
    logic [FREQ_BITS-1:0]  r_cur_freq;

    // Per-frame working registers
    logic [FREQ_BITS-1:0]  r_ft;
    logic [LEVEL_W-1:0]    r_vroot;
    logic [CW-1:0]         r_cnt_work;
    logic                  r_up;
    logic [FADE_W-1:0]     r_mul_a;
    logic [DW-1:0]         r_mul_b;
    t_out_beat             r_out;
    logic                  r_out_valid;

    // Unit hookups
    logic                  sq_start;
    logic [2*LEVEL_W-1:0]  sq_rad;
    logic                  sq_done;
    logic [LEVEL_W-1:0]    sq_root;
    logic [DW-1:0]         mul_step;

    logic                  in_acc;
    logic                  note_on;
    logic                  emit_go;
    logic [CW-1:0]         a_ext;
    logic [CW-1:0]         rel_end;
    logic [CW-1:0]         c_now;
    logic [CW-1:0]         c_pre;
    logic [CW-1:0]         w_inc;
    logic [DW-1:0]         freq_ext;
    logic [LEVEL_W-1:0]    env_step;
    logic [FREQ_BITS-1:0]  frq_step;
    logic                  env_rise;
    logic                  frq_rise;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign note_on     = (r_ft != '0);
    assign emit_go     = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);

    // Counter operands, compared at full precision
    always_comb begin
        a_ext   = CW'(r_attack_frames);
        rel_end = a_ext + CW'(1) + CW'(r_release_frames);
        c_now   = CW'(r_phase);
        w_inc   = r_cnt_work + CW'(1);
        if (!note_on) begin
            if (c_now != '0 && c_now <= a_ext) begin
                c_pre = a_ext + CW'(2);
            end else if (c_now > rel_end) begin
                c_pre = '0;
            end else begin
                c_pre = c_now;
            end
        end else begin
            c_pre = (c_now == '0) ? c_now : a_ext + CW'(2);
        end
    end

    // Steps out of the shared multiplier and direction compares
    always_comb begin
        env_step = LEVEL_W'(mul_step);
        frq_step = FREQ_BITS'(mul_step);
        env_rise = (r_env_tgt > r_env_level);
        frq_rise = (r_ft > r_cur_freq);
        freq_ext = DW'(r_cur_freq);
    end

    // Feed the root unit: velocity root on accept, level root later
    always_comb begin
        sq_start = in_acc || (r_state == S_LVL_START);
        if (r_state == S_IDLE) begin
            sq_rad = {i_in_data.velocity, {(2 * LEVEL_W - VEL_W){1'b0}}};
        end else begin
            sq_rad = (2 * LEVEL_W)'({r_env_level, {ENV_SHIFT{1'b0}}});
        end
    end

    nenv_sqrt #(
        .ROOT_W (LEVEL_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (sq_rad),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    nenv_mul #(
        .B_W (DW)
    ) u_mul (
        .i_clk  (i_clk),
        .i_coef (r_mul_a),
        .i_mag  (r_mul_b),
        .o_step (mul_step)
    );

    // Sequence one frame
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (in_acc) n_state = S_VROOT;
            S_VROOT:     if (sq_done) n_state = S_CNT_PRE;
            S_CNT_PRE:   n_state = S_CNT_UPD;
            S_CNT_UPD:   n_state = S_ENV_DIF;
            S_ENV_DIF:   n_state = S_ENV_MUL;
            S_ENV_MUL:   n_state = S_ENV_UPD;
            S_ENV_UPD:   n_state = note_on ? S_GLD_SQ : S_LVL_START;
            S_GLD_SQ:    n_state = S_GLD_DIF;
            S_GLD_DIF:   n_state = S_GLD_MUL;
            S_GLD_MUL:   n_state = S_GLD_UPD;
            S_GLD_UPD:   n_state = S_LVL_START;
            S_LVL_START: n_state = S_LVL_ROOT;
            S_LVL_ROOT:  if (sq_done) n_state = S_EMIT;
            S_EMIT:      if (emit_go) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Control and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_attack_frames  <= RST_ATTACK_FRAMES;
            r_release_frames <= RST_RELEASE_FRAMES;
            r_attack_fade    <= RST_ATTACK_FADE;
            r_release_fade   <= RST_RELEASE_FADE;
            r_freq_fade      <= RST_FREQ_FADE;
            r_phase          <= '0;
            r_env_level      <= '0;
            r_env_tgt        <= '0;
            r_cur_freq       <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state <= n_state;

            // Take configuration beats; unknown indexes drop
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ATTACK_FRAMES:  r_attack_frames  <= i_cfg_data[FRAMES_W-1:0];
                    CFG_RELEASE_FRAMES: r_release_frames <= i_cfg_data[FRAMES_W-1:0];
                    CFG_ATTACK_FADE:    r_attack_fade    <= i_cfg_data[FADE_W-1:0];
                    CFG_RELEASE_FADE:   r_release_fade   <= i_cfg_data[FADE_W-1:0];
                    CFG_FREQ_FADE:      r_freq_fade      <= i_cfg_data[FADE_W-1:0];
                    default: ;
                endcase
            end

            case (r_state)
                // Phase entry: snap frequency or retrigger
                S_CNT_PRE: begin
                    if (note_on && c_now == '0) begin
                        r_cur_freq <= r_ft;
                    end
                    if (note_on && c_now != '0) begin
                        r_env_tgt <= r_vroot;
                    end
                end
                // Attack, hold or release step
                S_CNT_UPD: begin
                    if (note_on && r_cnt_work < a_ext) begin
                        r_env_tgt <= r_vroot;
                        r_phase   <= COUNT_BITS'(w_inc);
                    end else if (note_on && r_cnt_work == a_ext + CW'(1)) begin
                        r_phase <= COUNT_BITS'(r_cnt_work);
                    end else if (!note_on && r_cnt_work > a_ext + CW'(1)) begin
                        r_env_tgt <= '0;
                        r_phase   <= (w_inc > rel_end) ? '0 : COUNT_BITS'(w_inc);
                    end else begin
                        r_phase <= COUNT_BITS'(r_cnt_work);
                    end
                end
                // Smooth the envelope toward its target
                S_ENV_UPD: begin
                    r_env_level <= r_up ? r_env_level + env_step
                                        : r_env_level - env_step;
                end
                // Glide the frequency toward the target
                S_GLD_UPD: begin
                    r_cur_freq <= r_up ? r_cur_freq + frq_step
                                       : r_cur_freq - frq_step;
                end
                default: ;
            endcase

            // Hold the result until the output beat is taken
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-frame working values
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_ft <= FREQ_BITS'(i_in_data.freq_target);
                end
            end
            S_VROOT: begin
                if (sq_done) begin
                    r_vroot <= sq_root;
                end
            end
            S_CNT_PRE: begin
                r_cnt_work <= c_pre;
            end
            // Pick the coefficient and distance for the envelope
            S_ENV_DIF: begin
                r_up    <= env_rise;
                r_mul_a <= env_rise ? r_attack_fade : r_release_fade;
                r_mul_b <= env_rise ? DW'(r_env_tgt - r_env_level)
                                    : DW'(r_env_level - r_env_tgt);
            end
            // Square the glide factor next
            S_ENV_UPD: begin
                r_mul_a <= r_freq_fade;
                r_mul_b <= DW'(r_freq_fade);
            end
            // Rounded square times the frequency distance
            S_GLD_DIF: begin
                r_up    <= frq_rise;
                r_mul_a <= mul_step[FADE_W-1:0];
                r_mul_b <= frq_rise ? DW'(r_ft - r_cur_freq)
                                    : DW'(r_cur_freq - r_ft);
            end
            S_EMIT: begin
                if (emit_go) begin
                    r_out.frequency <= freq_ext[FREQ_W-1:0];
                    r_out.level     <= sq_root[LEVEL_OUT_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### sim/note_envelope_with_glide_top_tb.sv
// Testbench for note_envelope_with_glide_top: frame stimulus, a scoreboard class
// that predicts each result beat, and randomized idling on both channels.
// Depends on rtl/nenv_pkg.sv and rtl/note_envelope_with_glide_top.sv.
`timescale 1ns / 100ps

module note_envelope_with_glide_top_tb;
    import nenv_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 3'd5;
    localparam int LONG_HOLD_CYCLES = 300;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    // Predicts envelope and glide per frame and holds the results still due
    class frame_scoreboard;
        longint unsigned attack_frames = 64'(RST_ATTACK_FRAMES);
        longint unsigned release_frames = 64'(RST_RELEASE_FRAMES);
        longint unsigned attack_fade = 64'(RST_ATTACK_FADE);
        longint unsigned release_fade = 64'(RST_RELEASE_FADE);
        longint unsigned freq_fade = 64'(RST_FREQ_FADE);
        longint unsigned frame_count = 0;
        longint unsigned env_level = 0;
        longint unsigned env_goal = 0;
        longint unsigned glide_freq = 0;
        t_out_beat due_results[$];
        int errors = 0;

        function longint unsigned floor_root(longint unsigned v);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            for (int b = 31; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= v) root = trial;
            end
            return root;
        endfunction

        // Step cur toward goal by coef * distance, Q0.16, rounded half up
        function longint unsigned slew(longint unsigned cur, longint unsigned goal,
                                       longint unsigned coef);
            if (goal > cur) return cur + ((coef * (goal - cur) + ROUND_HALF) >> 16);
            return cur - ((coef * (cur - goal) + ROUND_HALF) >> 16);
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ATTACK_FRAMES:  attack_frames = 64'(data);
                CFG_RELEASE_FRAMES: release_frames = 64'(data);
                CFG_ATTACK_FADE:    attack_fade = 64'(data[FADE_W-1:0]);
                CFG_RELEASE_FADE:   release_fade = 64'(data[FADE_W-1:0]);
                CFG_FREQ_FADE:      freq_fade = 64'(data[FADE_W-1:0]);
                default: ;
            endcase
        endfunction

        function void note_frame(t_in_beat beat);
            longint unsigned goal_freq;
            longint unsigned vel_root;
            longint unsigned rel_end;
            longint unsigned cnt;
            longint unsigned glide;
            bit note_on;
            t_out_beat res;
            goal_freq = 64'(beat.freq_target);
            vel_root = floor_root(longint'(beat.velocity) << 32) & 64'hFF_FFFF;
            rel_end = attack_frames + 1 + release_frames;
            cnt = frame_count;
            note_on = goal_freq != 0;

            // Retrigger and phase bookkeeping
            if (!note_on) begin
                if (cnt > 0 && cnt < attack_frames + 1) cnt = attack_frames + 2;
                else if (cnt > rel_end) cnt = 0;
            end else if (cnt == 0) begin
                glide_freq = goal_freq;
            end else begin
                cnt = attack_frames + 2;
                env_goal = vel_root;
            end

            // Advance attack or release
            if (note_on && cnt < attack_frames) begin
                env_goal = vel_root;
                cnt++;
            end else if (!note_on && cnt > attack_frames + 1) begin
                env_goal = 0;
                cnt++;
                if (cnt > rel_end) cnt = 0;
            end
            frame_count = cnt & ((64'd1 << COUNT_BITS_DEF) - 1);

            // Smooth the envelope
            if (env_goal > env_level) env_level = slew(env_level, env_goal, attack_fade);
            else env_level = slew(env_level, env_goal, release_fade);
            env_level &= 64'hFF_FFFF;

            // Glide only while a note is held
            if (note_on) begin
                glide = (freq_fade * freq_fade + ROUND_HALF) >> 16;
                glide_freq = slew(glide_freq, goal_freq, glide) &
                             ((64'd1 << FREQ_BITS_DEF) - 1);
            end

            res.frequency = glide_freq[FREQ_W-1:0];
            res.level = LEVEL_OUT_W'(floor_root(env_level << ENV_SHIFT));
            due_results.push_back(res);
        endfunction

        function void check_result(t_out_beat got);
            t_out_beat want;
            if (due_results.size() == 0) begin
                $display("%0t unexpected result: frequency %0d level %0d",
                         $time, got.frequency, got.level);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.frequency !== want.frequency) begin
                $display("%0t frequency mismatch: expected %0d actual %0d",
                         $time, want.frequency, got.frequency);
                errors++;
            end
            if (got.level !== want.level) begin
                $display("%0t level mismatch: expected %0d actual %0d",
                         $time, want.level, got.level);
                errors++;
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in_beat i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out_beat o_out_data;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    frame_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int long_hold_req = 0;
    int frames_sent = 0;
    longint unsigned cur_attack = 64'(RST_ATTACK_FRAMES);
    longint unsigned cur_release = 64'(RST_RELEASE_FRAMES);

    note_envelope_with_glide_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Check every result beat taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_data);
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && long_hold_req != 0) begin
                hold_left = long_hold_req;
                long_hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one frame beat and hold it until taken
    task automatic send_frame(input logic [FREQ_W-1:0] freq, input logic [VEL_W-1:0] vel);
        t_in_beat beat;
        beat.freq_target = freq;
        beat.velocity = vel;
        i_in_valid <= 1'b1;
        i_in_data <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_frame(beat);
        frames_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Drop valid and wait until every result is back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic write_cfg_beat(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // Program all registers while idle, then set the idling mode
    task automatic reconfigure(input logic [CFG_DATA_W-1:0] att, rel, att_fade, rel_fade,
                               glide_fade, input t_idle_mode mode);
        drain();
        write_cfg_beat(CFG_ATTACK_FRAMES, att);
        write_cfg_beat(CFG_RELEASE_FRAMES, rel);
        write_cfg_beat(CFG_ATTACK_FADE, att_fade);
        write_cfg_beat(CFG_RELEASE_FADE, rel_fade);
        write_cfg_beat(CFG_FREQ_FADE, glide_fade);
        i_cfg_valid <= 1'b0;
        cur_attack = 64'(att);
        cur_release = 64'(rel);
        send_idle_pct = (mode == IDLE_SEND) ? 51 : (mode == IDLE_BOTH) ? 10 : 0;
        recv_stall_pct = (mode == IDLE_RECV) ? 51 : (mode == IDLE_BOTH) ? 10 : 0;
    endtask

    // One note: attack and hold, then a release of random length
    task automatic play_note();
        logic [FREQ_W-1:0] freq;
        logic [VEL_W-1:0] vel;
        int max_on;
        int max_off;
        int n_on;
        int n_off;
        max_on = (cur_attack > 12 ? 12 : int'(cur_attack)) + 4;
        max_off = (cur_release > 12 ? 12 : int'(cur_release)) + 4;
        case ($urandom_range(3))
            0: freq = FREQ_W'($urandom_range(255));
            1: freq = FREQ_W'(24'hFF_FFFF - $urandom_range(255));
            default: freq = FREQ_W'($urandom);
        endcase
        if (freq == 0) freq = 1;
        case ($urandom_range(5))
            0: vel = '0;
            1: vel = '1;
            default: vel = VEL_W'($urandom);
        endcase
        n_on = $urandom_range(max_on, 1);
        n_off = $urandom_range(max_off, 0);
        for (int i = 0; i < n_on; i++) begin
            // Occasionally move the pitch or velocity mid-note
            if ($urandom_range(9) == 0) freq = FREQ_W'($urandom_range(24'hFF_FFFF, 1));
            if ($urandom_range(9) == 0) vel = VEL_W'($urandom);
            send_frame(freq, vel);
        end
        for (int i = 0; i < n_off; i++) send_frame('0, VEL_W'($urandom));
    endtask

    // Mostly whole notes, some raw noise; optional back-pressure tests
    task automatic random_frames(input int count, input bit pressure);
        int stop_at;
        int hold_at;
        int pause_at;
        bit held;
        bit paused;
        stop_at = frames_sent + count;
        hold_at = frames_sent + count / 3;
        pause_at = frames_sent + 2 * count / 3;
        held = 1'b0;
        paused = 1'b0;
        while (frames_sent < stop_at) begin
            if (pressure && !held && frames_sent >= hold_at) begin
                long_hold_req = LONG_HOLD_CYCLES;
                held = 1'b1;
            end
            if (pressure && !paused && frames_sent >= pause_at) begin
                drain();
                paused = 1'b1;
            end
            if ($urandom_range(99) < 75) begin
                play_note();
            end else begin
                repeat ($urandom_range(5, 1)) begin
                    send_frame(($urandom_range(2) == 0) ? 24'd0 : 24'($urandom),
                               VEL_W'($urandom));
                end
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: loudest, highest note, then note off
        send_frame(24'hFF_FFFF, 16'hFFFF);
        send_frame(24'd0, 16'h0000);

        // Short attack and release; the unmapped index must change nothing
        drain();
        write_cfg_beat(CFG_UNMAPPED, 23'h7F_FFFF);
        i_cfg_valid <= 1'b0;
        reconfigure(23'd3, 23'd4, 23'd40000, 23'd20000, 23'd30000, IDLE_NONE);
        send_frame(24'd1, 16'hFFFF);
        // note off inside the attack jumps to release
        send_frame(24'd0, 16'h1234);
        repeat (5) send_frame(24'd0, 16'h0000);
        repeat (4) send_frame(24'hFF_FFFF, 16'hFFFF);
        repeat (2) send_frame(24'd0, 16'hFFFF);
        // new note during the release takes over
        repeat (2) send_frame(24'h00_0100, 16'h4000);
        repeat (6) send_frame(24'd0, 16'h0000);
        send_frame(24'h80_0000, 16'h0000);
        send_frame(24'h80_0000, 16'h0001);
        random_frames(40, 1'b0);

        // Zero attack: frequency snaps, target stays; fades at maximum
        reconfigure(23'd0, 23'd2, 23'd65535, 23'd65535, 23'd65535, IDLE_SEND);
        repeat (3) send_frame(24'd12345, 16'h8000);
        send_frame(24'h55_5555, 16'hAAAA);
        random_frames(60, 1'b0);

        // Long frame counts, zero coefficients
        reconfigure(23'd4410000, 23'd4410000, 23'd0, 23'd0, 23'd0, IDLE_RECV);
        random_frames(50, 1'b0);

        reconfigure(23'd1, 23'd0, 23'($urandom_range(65535)), 23'($urandom_range(65535)),
                    23'($urandom_range(65535)), IDLE_BOTH);
        random_frames(60, 1'b0);

        // Fade writes with upper data bits set; back-pressure and a full pause
        reconfigure(23'($urandom_range(8)), 23'($urandom_range(8)), 23'($urandom),
                    23'($urandom), 23'($urandom), IDLE_NONE);
        random_frames(70, 1'b1);

        reconfigure(23'($urandom_range(12)), 23'($urandom_range(12)),
                    23'($urandom_range(65535)), 23'($urandom_range(65535)),
                    23'($urandom_range(65535)), IDLE_SEND);
        random_frames(60, 1'b0);

        reconfigure(23'($urandom_range(12)), 23'($urandom_range(12)),
                    23'($urandom_range(65535)), 23'($urandom_range(65535)),
                    23'($urandom_range(65535)), IDLE_RECV);
        random_frames(60, 1'b0);

        reconfigure(23'($urandom_range(6)), 23'($urandom_range(20)),
                    23'($urandom_range(65535)), 23'($urandom_range(65535)),
                    23'($urandom_range(65535)), IDLE_BOTH);
        random_frames(60, 1'b0);

        reconfigure(23'd0, 23'd0, 23'd1, 23'd1, 23'd1, IDLE_NONE);
        random_frames(40, 1'b0);

        // Let the last results come back, then watch for strays
        drain();
        repeat (80) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Timeout
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

### filelist.f
rtl/nenv_pkg.sv
rtl/nenv_sqrt.sv
rtl/nenv_mul.sv
rtl/note_envelope_with_glide_top.sv
sim/note_envelope_with_glide_top_tb.sv
